// ===== sv/glyph_text_framebuffer_renderer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the glyph text frame buffer renderer
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_FRAMEBUFFER_RENDERER_UNIT_ASSERT_SVH
`define GLYPH_TEXT_FRAMEBUFFER_RENDERER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define GTFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GTFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GTFR_ASSERT_IMP(lbl, ante, cons, msg)
`define GTFR_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/gtfr_pkg.sv =====
// ----------------------------------------------------------------------------
// gtfr_pkg
// Shared constants, command codes, font table and control structs.
// ----------------------------------------------------------------------------
package gtfr_pkg;

    localparam int SCREEN_WIDTH  = 84;
    localparam int SCREEN_BANKS  = 6;
    localparam int ROWS_PER_BANK = 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * SCREEN_BANKS;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int BANK_W        = (SCREEN_BANKS > 1) ? $clog2(SCREEN_BANKS) : 1;

    localparam int GLYPH_COUNT = 96;
    localparam int GLYPH_COLS  = 5;
    localparam int GIDX_W      = $clog2(GLYPH_COUNT);
    localparam int STEPS       = GLYPH_COLS * 2;
    localparam int STEP_W      = $clog2(STEPS);

    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_SETC  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LAST    = 8'h7F;

    localparam logic [7:0] COL_ADVANCE   = 8'd6;
    localparam logic [7:0] SPACE_ADVANCE = 8'd2;
    localparam logic [7:0] LINE_ADVANCE  = 8'd8;

    // Work class of an accepted item, decided by the datapath.
    localparam logic [1:0] KIND_NOW   = 2'd0;
    localparam logic [1:0] KIND_GLYPH = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic tgt_rd;
        logic tgt_wr;
        logic step_inc;
        logic str_rd;
        logic load_out;
    } gtfr_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       tgt_valid;
        logic       step_last;
        logic       clr_last;
        logic       out_free;
    } gtfr_stat_t;

    localparam logic [7:0] FONT_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5f,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7f,8'h14,8'h7f,8'h14},
        '{8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1c,8'h00},
        '{8'h14,8'h08,8'h3e,8'h08,8'h14}, '{8'h08,8'h08,8'h3e,8'h08,8'h08},
        '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3e,8'h51,8'h49,8'h45,8'h3e}, '{8'h00,8'h42,8'h7f,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4b,8'h31},
        '{8'h18,8'h14,8'h12,8'h7f,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3c,8'h4a,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1e},
        '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h32,8'h49,8'h79,8'h41,8'h3e}, '{8'h7e,8'h11,8'h11,8'h11,8'h7e},
        '{8'h7f,8'h49,8'h49,8'h49,8'h36}, '{8'h3e,8'h41,8'h41,8'h41,8'h22},
        '{8'h7f,8'h41,8'h41,8'h22,8'h1c}, '{8'h7f,8'h49,8'h49,8'h49,8'h41},
        '{8'h7f,8'h09,8'h09,8'h09,8'h01}, '{8'h3e,8'h41,8'h49,8'h49,8'h7a},
        '{8'h7f,8'h08,8'h08,8'h08,8'h7f}, '{8'h00,8'h41,8'h7f,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3f,8'h01}, '{8'h7f,8'h08,8'h14,8'h22,8'h41},
        '{8'h7f,8'h40,8'h40,8'h40,8'h40}, '{8'h7f,8'h02,8'h0c,8'h02,8'h7f},
        '{8'h7f,8'h04,8'h08,8'h10,8'h7f}, '{8'h3e,8'h41,8'h41,8'h41,8'h3e},
        '{8'h7f,8'h09,8'h09,8'h09,8'h06}, '{8'h3e,8'h41,8'h51,8'h21,8'h5e},
        '{8'h7f,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7f,8'h01,8'h01}, '{8'h3f,8'h40,8'h40,8'h40,8'h3f},
        '{8'h1f,8'h20,8'h40,8'h20,8'h1f}, '{8'h3f,8'h40,8'h38,8'h40,8'h3f},
        '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7f,8'h41,8'h41,8'h00},
        '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7f,8'h00},
        '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h7f,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h38,8'h44,8'h44,8'h48,8'h7f}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h08,8'h7e,8'h09,8'h01,8'h02}, '{8'h0c,8'h52,8'h52,8'h52,8'h3e},
        '{8'h7f,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7d,8'h40,8'h00},
        '{8'h20,8'h40,8'h44,8'h3d,8'h00}, '{8'h7f,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h41,8'h7f,8'h40,8'h00}, '{8'h7c,8'h04,8'h18,8'h04,8'h78},
        '{8'h7c,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h7c,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7c},
        '{8'h7c,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h04,8'h3f,8'h44,8'h40,8'h20}, '{8'h3c,8'h40,8'h40,8'h20,8'h7c},
        '{8'h1c,8'h20,8'h40,8'h20,8'h1c}, '{8'h3c,8'h40,8'h30,8'h40,8'h3c},
        '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0c,8'h50,8'h50,8'h50,8'h3c},
        '{8'h44,8'h64,8'h54,8'h4c,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
        '{8'h00,8'h00,8'h7f,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
        '{8'h10,8'h08,8'h08,8'h10,8'h08}, '{8'h78,8'h46,8'h41,8'h46,8'h78}
    };

endpackage

// ===== sv/gtfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtfr_ctrl
// Sequencer for the renderer: clear pass, glyph read-modify-write, reads.
// ----------------------------------------------------------------------------
module gtfr_ctrl
    import gtfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  gtfr_stat_t stat,
    output gtfr_cmd_t  cmd
);

    `include "glyph_text_framebuffer_renderer_unit_assert.svh"

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_CLR  = 3'd2;
    localparam logic [2:0] ST_DRD  = 3'd3;
    localparam logic [2:0] ST_DWR  = 3'd4;
    localparam logic [2:0] ST_RRD  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = accept;
        unique case (state_reg)
            ST_INIT, ST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_FIN;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (stat.kind)
                        KIND_GLYPH: state_next = ST_DRD;
                        KIND_CLEAR: state_next = ST_CLR;
                        KIND_READ:  state_next = ST_RRD;
                        default:    state_next = ST_FIN;
                    endcase
                end
            end
            ST_DRD:
            begin
                // Off-screen or unused targets are skipped with no store access.
                if (stat.tgt_valid)
                begin
                    cmd.tgt_rd = 1'b1;
                    state_next = ST_DWR;
                end
                else
                begin
                    cmd.step_inc = 1'b1;
                    if (stat.step_last)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_DWR:
            begin
                cmd.tgt_wr   = 1'b1;
                cmd.step_inc = 1'b1;
                state_next   = stat.step_last ? ST_FIN : ST_DRD;
            end
            ST_RRD:
            begin
                cmd.str_rd = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `GTFR_ASSERT_NXT(a_glyph_starts, accept && stat.kind == KIND_GLYPH,
        state_reg == ST_DRD, "glyph transfer did not start the column walk")
    `GTFR_ASSERT_IMP(a_write_after_read, state_reg == ST_DWR,
        $past(state_reg) == ST_DRD, "store write without a preceding read")
    `GTFR_ASSERT_IMP(a_load_when_free, cmd.load_out, stat.out_free,
        "result loaded while the output register is still full")
    `GTFR_ASSERT_NXT(a_clear_ends, state_reg == ST_CLR && stat.clr_last,
        state_reg == ST_FIN, "clear pass did not end at the last byte")

endmodule

// ===== sv/gtfr_dp.sv =====
// ----------------------------------------------------------------------------
// gtfr_dp
// Datapath: cursor, glyph latch, frame store, byte merge and result register.
// ----------------------------------------------------------------------------
module gtfr_dp
    import gtfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  gtfr_cmd_t   cmd,
    output gtfr_stat_t  stat,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_data,
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tuser
);

    logic [1:0]        in_cmd;
    logic [7:0]        in_code;
    logic [7:0]        in_row;
    logic [7:0]        in_col;
    logic [ADDR_W-1:0] in_addr;
    logic              is_newline;
    logic              is_space;
    logic              is_glyph;
    logic [GIDX_W-1:0] gidx;
    logic [1:0]        kind;

    logic              order_reg;
    logic [7:0]        cur_row_reg;
    logic [7:0]        cur_col_reg;
    logic [7:0]        glyph_reg [GLYPH_COLS];
    logic [7:0]        org_col_reg;
    logic [2:0]        row_off_reg;
    logic [4:0]        bank_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_ok_reg;
    logic              status_reg;

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        q_reg;

    logic [2:0]        col_j;
    logic              half;
    logic [8:0]        tgt_x;
    logic [5:0]        tgt_bank;
    logic [ADDR_W-1:0] tgt_addr;
    logic [15:0]       data_wide;
    logic [15:0]       mask_wide;
    logic [7:0]        put_data;
    logic [7:0]        put_mask;
    logic [7:0]        merged;

    logic              out_valid_reg;
    logic              out_status_reg;
    logic [7:0]        out_data_reg;
    logic [7:0]        out_row_reg;
    logic [7:0]        out_col_reg;

    // tdata: char_code, new_row, new_col, read_address; tuser: cmd.
    assign in_cmd  = s_axis_tuser;
    assign in_code = s_axis_tdata[7:0];
    assign in_row  = s_axis_tdata[15:8];
    assign in_col  = s_axis_tdata[23:16];
    assign in_addr = s_axis_tdata[32:24];

    assign is_newline = (in_code == CHAR_NEWLINE);
    assign is_space   = (in_code == CHAR_SPACE);
    assign is_glyph   = (in_code > CHAR_SPACE) && (in_code <= CHAR_LAST);
    assign gidx       = is_glyph ? GIDX_W'(in_code - CHAR_SPACE) : '0;

    always_comb
    begin
        unique case (in_cmd)
            CMD_DRAW:  kind = is_glyph ? KIND_GLYPH : KIND_NOW;
            CMD_CLEAR: kind = KIND_CLEAR;
            CMD_READ:  kind = KIND_READ;
            default:   kind = KIND_NOW;
        endcase
    end

    assign stat.kind = kind;

    // One step covers one glyph column in one bank: the lower half hits the
    // cursor's bank, the upper half the bank below when the row is unaligned.
    assign col_j    = step_reg[STEP_W-1:1];
    assign half     = step_reg[0];
    assign tgt_x    = {1'b0, org_col_reg} + 9'(col_j);
    assign tgt_bank = {1'b0, bank_reg} + 6'(half);
    assign tgt_addr = ADDR_W'(tgt_bank[BANK_W-1:0]) * ADDR_W'(SCREEN_WIDTH)
                    + ADDR_W'(tgt_x[7:0]);

    assign stat.tgt_valid = (tgt_x < 9'(SCREEN_WIDTH)) && (tgt_bank < 6'(SCREEN_BANKS))
                         && (!half || (row_off_reg != 3'd0));
    assign stat.step_last = (step_reg == STEP_W'(STEPS - 1));
    assign stat.clr_last  = (clr_addr_reg == ADDR_W'(STORE_BYTES - 1));
    assign stat.out_free  = !out_valid_reg || m_axis_tready;

    assign data_wide = {8'h00, glyph_reg[col_j]} << row_off_reg;
    assign mask_wide = 16'h00FF << row_off_reg;
    assign put_data  = half ? data_wide[15:8] : data_wide[7:0];
    assign put_mask  = half ? mask_wide[15:8] : mask_wide[7:0];
    assign merged    = (q_reg & ~put_mask) | (put_data & put_mask);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            mem[clr_addr_reg] <= 8'h00;
        end
        else if (cmd.tgt_wr)
        begin
            mem[tgt_addr] <= merged;
        end
        if (cmd.tgt_rd)
        begin
            q_reg <= mem[tgt_addr];
        end
        else if (cmd.str_rd && rd_ok_reg)
        begin
            q_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= 1'b0;
            cur_row_reg   <= 8'd0;
            cur_col_reg   <= 8'd0;
            step_reg      <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                order_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                step_reg     <= '0;
                clr_addr_reg <= '0;
                unique case (in_cmd)
                    CMD_DRAW:
                    begin
                        if (is_newline)
                        begin
                            cur_row_reg <= cur_row_reg + LINE_ADVANCE;
                            cur_col_reg <= 8'd0;
                        end
                        else if (is_space)
                        begin
                            cur_col_reg <= cur_col_reg + SPACE_ADVANCE;
                        end
                        else if (is_glyph)
                        begin
                            cur_col_reg <= cur_col_reg + COL_ADVANCE;
                        end
                    end
                    CMD_SETC:
                    begin
                        cur_row_reg <= in_row;
                        cur_col_reg <= in_col;
                    end
                    CMD_CLEAR:
                    begin
                        cur_row_reg <= 8'd0;
                        cur_col_reg <= 8'd0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                if (cmd.step_inc)
                begin
                    step_reg <= step_reg + 1'b1;
                end
                if (cmd.clr_wr)
                begin
                    clr_addr_reg <= stat.clr_last ? '0 : clr_addr_reg + 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int j = 0; j < GLYPH_COLS; j++)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    glyph_reg[j][k] <= order_reg ? FONT_ROM[gidx][j][7 - k]
                                                 : FONT_ROM[gidx][j][k];
                end
            end
            org_col_reg <= cur_col_reg;
            row_off_reg <= cur_row_reg[2:0];
            bank_reg    <= cur_row_reg[7:3];
            rd_addr_reg <= in_addr;
            rd_ok_reg   <= (in_cmd == CMD_READ) && (in_addr < ADDR_W'(STORE_BYTES));
            status_reg  <= (in_cmd == CMD_DRAW) && !is_glyph && !is_space && !is_newline;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_data_reg   <= rd_ok_reg ? q_reg : 8'h00;
            out_row_reg    <= cur_row_reg;
            out_col_reg    <= cur_col_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_col_reg, out_row_reg, out_data_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

// ===== sv/glyph_text_framebuffer_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_text_framebuffer_renderer_unit
// Draws 5x8 font characters into an 84x48 banked monochrome frame store.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis stream (cmd in tuser) and each produces one
// result transfer on m_axis: status in tuser, read byte and cursor in tdata.
// The cfg channel writes the glyph bit order and is always ready.
// Steps from accepted transfer to result valid:
//   set cursor, space, newline, undrawable code: straight to the result
//   read store byte: one store read, then the result
//   glyph: the ten column and bank steps, each a store read and then a
//     write for an on-screen byte, or skipped with no store access for a
//     byte off the screen; a glyph may straddle two banks
//   clear: one store byte written per cycle, then the result
// The block takes one command at a time.
// After reset the store is cleared by a pass over all 504 bytes with
// s_axis_tready low. A finished result waits in the output register; the
// next command is accepted while it waits, and that command finishes only
// once the receiver has taken the earlier result.
module glyph_text_framebuffer_renderer_unit
    import gtfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // char_code, new_row, new_col, read_address
    input  logic [1:0]  s_axis_tuser,  // cmd
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // read_data, cursor_row_now, cursor_col_now
    output logic        m_axis_tuser   // status
);

    gtfr_cmd_t  cmd;
    gtfr_stat_t stat;

    assign cfg_ready = 1'b1;

    gtfr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    gtfr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
